/* design/atcbp_pkg.sv */
// ----------------------------------------------------------------------------
// AT command byte parser package
// Shared codes and the result beat type.
// ----------------------------------------------------------------------------
package atcbp_pkg;

    typedef enum logic [1:0] {
        FUNC_BYTE  = 2'd0,
        FUNC_ARM   = 2'd1,
        FUNC_ABORT = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        KIND_LINE_CHAR   = 3'd0,
        KIND_LINE_END    = 3'd1,
        KIND_LINE_CANCEL = 3'd2,
        KIND_LINE_OVFL   = 3'd3,
        KIND_DATA_BYTE   = 3'd4,
        KIND_DATA_DONE   = 3'd5,
        KIND_ARM_REJECT  = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ENC_ERR = 2'd1,
        STATUS_ABORTED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_WAIT_A  = 2'd0,
        PH_GOT_A   = 2'd1,
        PH_IN_LINE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic [7:0] count;
        logic       data_last;
        logic [1:0] done_status;
    } result_t;

endpackage

/* design/atcbp_in_if.sv */
// ----------------------------------------------------------------------------
// AT command byte parser input channel
// Valid/ready channel carrying one parser event per beat.
// ----------------------------------------------------------------------------
interface atcbp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic [8:0] arm_length;
    logic       arm_hex;

    modport source (output valid, output func, output rx_byte, output arm_length,
                    output arm_hex, input ready);
    modport sink (input valid, input func, input rx_byte, input arm_length,
                  input arm_hex, output ready);
endinterface

/* design/atcbp_out_if.sv */
// ----------------------------------------------------------------------------
// AT command byte parser output channel
// Valid/ready channel carrying one parser result per beat.
// ----------------------------------------------------------------------------
interface atcbp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [7:0] count;
    logic       data_last;
    logic [1:0] done_status;

    modport source (output valid, output kind, output out_byte, output count,
                    output data_last, output done_status, input ready);
    modport sink (input valid, input kind, input out_byte, input count,
                  input data_last, input done_status, output ready);
endinterface

/* design/atcbp_core.sv */
// ----------------------------------------------------------------------------
// AT command byte parser core
// Parser state registers and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
module atcbp_core #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          func,
    input  logic [7:0]          rx_byte,
    input  logic [8:0]          arm_length,
    input  logic                arm_hex,
    output logic                res_valid,
    output atcbp_pkg::result_t  res
);

    localparam int LEN_W = $clog2(BUFFER_DEPTH);

    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    atcbp_pkg::phase_t phase_reg, phase_next;
    logic [LEN_W-1:0]  line_len_reg, line_len_next;
    logic              active_reg, active_next;
    logic [LEN_W-1:0]  target_reg, target_next;
    logic [LEN_W-1:0]  recv_reg, recv_next;
    logic              hex_reg, hex_next;
    logic              odd_reg, odd_next;
    logic [3:0]        high_reg, high_next;

    logic              hex_ok;
    logic [3:0]        hex_val;
    logic [LEN_W-1:0]  recv_inc;
    logic [7:0]        upper;
    logic              in_line;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (rx_byte inside {[8'h30:8'h39]})
        begin
            hex_val = rx_byte[3:0];
        end
        else if (rx_byte inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            hex_val = 4'(rx_byte[3:0] + 4'd9);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign upper    = (rx_byte inside {[8'h61:8'h7A]}) ? (rx_byte - 8'd32) : rx_byte;
    assign recv_inc = recv_reg + LEN_W'(1);
    assign in_line  = (phase_reg == atcbp_pkg::PH_IN_LINE);

    always_comb
    begin
        phase_next    = phase_reg;
        line_len_next = line_len_reg;
        active_next   = active_reg;
        target_next   = target_reg;
        recv_next     = recv_reg;
        hex_next      = hex_reg;
        odd_next      = odd_reg;
        high_next     = high_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (accept)
        begin
            case (atcbp_pkg::func_t'(func))
                atcbp_pkg::FUNC_BYTE:
                begin
                    if (active_reg)
                    begin
                        if (hex_reg && !hex_ok)
                        begin
                            res_valid       = 1'b1;
                            res.kind        = atcbp_pkg::KIND_DATA_DONE;
                            res.count       = 8'(recv_reg);
                            res.done_status = atcbp_pkg::STATUS_ENC_ERR;
                            active_next = 1'b0;
                            target_next = '0;
                            recv_next   = '0;
                            hex_next    = 1'b0;
                            odd_next    = 1'b0;
                            high_next   = '0;
                        end
                        else if (hex_reg && !odd_reg)
                        begin
                            high_next = hex_val;
                            odd_next  = 1'b1;
                        end
                        else
                        begin
                            res_valid    = 1'b1;
                            res.kind     = atcbp_pkg::KIND_DATA_BYTE;
                            res.out_byte = hex_reg ? {high_reg, hex_val} : rx_byte;
                            res.count    = 8'(recv_inc);
                            odd_next     = 1'b0;
                            recv_next    = recv_inc;
                            if (recv_inc == target_reg)
                            begin
                                res.data_last = 1'b1;
                                active_next = 1'b0;
                                target_next = '0;
                                recv_next   = '0;
                                hex_next    = 1'b0;
                                high_next   = '0;
                            end
                        end
                    end
                    else if (rx_byte == CH_LF)
                    begin
                        phase_next = phase_reg;
                    end
                    else if (rx_byte == CH_ESC)
                    begin
                        phase_next    = atcbp_pkg::PH_WAIT_A;
                        line_len_next = '0;
                        if (in_line)
                        begin
                            res_valid = 1'b1;
                            res.kind  = atcbp_pkg::KIND_LINE_CANCEL;
                            res.count = 8'(line_len_reg);
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            atcbp_pkg::PH_GOT_A:
                            begin
                                if (rx_byte == "T" || rx_byte == "t")
                                begin
                                    phase_next    = atcbp_pkg::PH_IN_LINE;
                                    line_len_next = LEN_W'(2);
                                end
                                else
                                begin
                                    phase_next    = atcbp_pkg::PH_WAIT_A;
                                    line_len_next = '0;
                                end
                            end
                            atcbp_pkg::PH_IN_LINE:
                            begin
                                res_valid = 1'b1;
                                if (rx_byte == CH_CR)
                                begin
                                    res.kind      = atcbp_pkg::KIND_LINE_END;
                                    res.count     = 8'(line_len_reg);
                                    phase_next    = atcbp_pkg::PH_WAIT_A;
                                    line_len_next = '0;
                                end
                                else if (line_len_reg >= LEN_W'(BUFFER_DEPTH - 1))
                                begin
                                    res.kind      = atcbp_pkg::KIND_LINE_OVFL;
                                    res.count     = 8'(line_len_reg);
                                    phase_next    = atcbp_pkg::PH_WAIT_A;
                                    line_len_next = '0;
                                end
                                else
                                begin
                                    res.kind      = atcbp_pkg::KIND_LINE_CHAR;
                                    res.out_byte  = upper;
                                    line_len_next = line_len_reg + LEN_W'(1);
                                end
                            end
                            default:
                            begin
                                if (rx_byte == "A" || rx_byte == "a")
                                begin
                                    phase_next    = atcbp_pkg::PH_GOT_A;
                                    line_len_next = LEN_W'(1);
                                end
                                else
                                begin
                                    phase_next    = atcbp_pkg::PH_WAIT_A;
                                    line_len_next = '0;
                                end
                            end
                        endcase
                    end
                end
                atcbp_pkg::FUNC_ARM:
                begin
                    if (active_reg || arm_length >= 9'(BUFFER_DEPTH))
                    begin
                        res_valid = 1'b1;
                        res.kind  = atcbp_pkg::KIND_ARM_REJECT;
                    end
                    else if (arm_length == 9'd0)
                    begin
                        res_valid     = 1'b1;
                        res.kind      = atcbp_pkg::KIND_DATA_DONE;
                        res.data_last = 1'b1;
                    end
                    else
                    begin
                        phase_next    = atcbp_pkg::PH_WAIT_A;
                        line_len_next = '0;
                        active_next   = 1'b1;
                        target_next   = arm_length[LEN_W-1:0];
                        recv_next     = '0;
                        hex_next      = arm_hex;
                        odd_next      = 1'b0;
                        high_next     = '0;
                        if (in_line)
                        begin
                            res_valid = 1'b1;
                            res.kind  = atcbp_pkg::KIND_LINE_CANCEL;
                            res.count = 8'(line_len_reg);
                        end
                    end
                end
                atcbp_pkg::FUNC_ABORT:
                begin
                    if (active_reg)
                    begin
                        res_valid       = 1'b1;
                        res.kind        = atcbp_pkg::KIND_DATA_DONE;
                        res.count       = 8'(recv_reg);
                        res.done_status = atcbp_pkg::STATUS_ABORTED;
                        active_next = 1'b0;
                        target_next = '0;
                        recv_next   = '0;
                        hex_next    = 1'b0;
                        odd_next    = 1'b0;
                        high_next   = '0;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= atcbp_pkg::PH_WAIT_A;
            line_len_reg <= '0;
            active_reg   <= 1'b0;
            target_reg   <= '0;
            recv_reg     <= '0;
            hex_reg      <= 1'b0;
            odd_reg      <= 1'b0;
            high_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            line_len_reg <= line_len_next;
            active_reg   <= active_next;
            target_reg   <= target_next;
            recv_reg     <= recv_next;
            hex_reg      <= hex_next;
            odd_reg      <= odd_next;
            high_reg     <= high_next;
        end
    end

endmodule

/* design/atcbp_out_queue.sv */
// ----------------------------------------------------------------------------
// AT command byte parser result queue
// Two-entry result register with skid slot; decouples input from a stalled sink.
// ----------------------------------------------------------------------------
module atcbp_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  atcbp_pkg::result_t push_data,
    output logic               has_room,
    output logic               out_valid,
    input  logic               out_ready,
    output atcbp_pkg::result_t out_data
);

    atcbp_pkg::result_t slot_reg [2];
    logic [1:0]         cnt_reg, cnt_next;
    logic               head_reg, head_next;
    logic               tail_reg, tail_next;
    logic               pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[head_reg];
    assign has_room  = (cnt_reg != 2'd2);

    always_comb
    begin
        head_next = pop  ? ~head_reg : head_reg;
        tail_next = push ? ~tail_reg : tail_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            head_reg <= 1'b0;
            tail_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

endmodule

/* design/at_command_byte_parser_top.sv */
// ----------------------------------------------------------------------------
// AT command byte parser top level
// Usage:
//   in_ch  carries one event per beat: a received byte, an arm of a data read
//          (length and encoding) or an abort. A beat is taken when valid and
//          ready are both high.
//   out_ch carries at most one result per input beat, in order.
//   Results: each is formed combinationally and registered in the queue.
//   Throughput: one input beat per cycle while the queue has room; the
//   parser state is updated by a single pass of logic at the input beat,
//   so consecutive beats never wait on each other.
//   Stall: results go into a two-entry queue; in_ch.ready drops only while
//   both entries are full, so one beat can still be taken while a result
//   waits on a stalled receiver.
//   Reset: rst_n clears the parser to waiting for A, leaves data mode and
//   empties the queue; no beat is lost or produced by reset itself.
// ----------------------------------------------------------------------------
module at_command_byte_parser_top #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    atcbp_in_if.sink   in_ch,
    atcbp_out_if.source out_ch
);

    logic               accept;
    logic               res_valid;
    atcbp_pkg::result_t res;
    atcbp_pkg::result_t head;
    logic               has_room;

    assign in_ch.ready = has_room;
    assign accept      = in_ch.valid && has_room;

    atcbp_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (in_ch.func),
        .rx_byte    (in_ch.rx_byte),
        .arm_length (in_ch.arm_length),
        .arm_hex    (in_ch.arm_hex),
        .res_valid  (res_valid),
        .res        (res)
    );

    atcbp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .has_room  (has_room),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (head)
    );

    assign out_ch.kind        = head.kind;
    assign out_ch.out_byte    = head.out_byte;
    assign out_ch.count       = head.count;
    assign out_ch.data_last   = head.data_last;
    assign out_ch.done_status = head.done_status;

endmodule

/* tb/tb_at_command_byte_parser_top.sv */
// ----------------------------------------------------------------------------
// AT command byte parser testbench
// Drives parser events (received bytes, data read arms, aborts) with random
// gaps on both channels. Predicts each result beat from an independent model
// of the parser state and checks every output beat against the oldest
// prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_at_command_byte_parser_top;

    localparam int          BUFFER_DEPTH = 256;
    localparam int          LINE_MAX     = BUFFER_DEPTH - 1;
    localparam int          RANDOM_ITEMS = 1450;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          IDLE_PCT     = 28;
    localparam logic [7:0]  CH_A         = 8'h41;
    localparam logic [7:0]  CH_A_LC      = 8'h61;
    localparam logic [7:0]  CH_T         = 8'h54;
    localparam logic [7:0]  CH_T_LC      = 8'h74;
    localparam logic [7:0]  CH_CR        = 8'h0D;
    localparam logic [7:0]  CH_LF        = 8'h0A;
    localparam logic [7:0]  CH_ESC       = 8'h1B;
    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [7:0]  CH_Z_LC      = 8'h7A;
    localparam logic [7:0]  CH_F_UC      = 8'h46;
    localparam logic [7:0]  CH_F_LC      = 8'h66;
    localparam logic [7:0]  CH_G_UC      = 8'h47;
    localparam logic [7:0]  CH_H_LC      = 8'h68;
    localparam logic [7:0]  CH_X_LC      = 8'h78;
    localparam logic [7:0]  CH_FOUR      = 8'h34;

    typedef struct {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic [8:0] arm_length;
        logic       arm_hex;
    } parser_event_t;

    logic clk = 1'b0;
    logic rst_n;

    atcbp_in_if  in_ch ();
    atcbp_out_if out_ch ();

    at_command_byte_parser_top #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    parser_event_t        event_q[$];
    atcbp_pkg::result_t   expected_results[$];

    // predicted parser state
    atcbp_pkg::phase_t line_phase;
    logic [7:0] line_len;
    bit         data_on;
    logic [7:0] data_tgt;
    logic [7:0] data_cnt;
    bit         hex_on;
    bit         nibble_low;
    logic [3:0] hi_nibble;

    int  cycle_cnt;
    int  beats_in;
    int  beats_out;
    int  mismatches;
    int  kind_seen[7];
    bit  in_fire;
    bit  calm;

    // bit 4 set marks a byte that is no hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
            return {1'b0, 4'(ch - "0")};
        if (ch >= "A" && ch <= "F")
            return {1'b0, 4'(ch - "A" + 8'd10)};
        if (ch >= "a" && ch <= "f")
            return {1'b0, 4'(ch - "a" + 8'd10)};
        return 5'h10;
    endfunction

    function automatic void clear_line();
        line_phase = atcbp_pkg::PH_WAIT_A;
        line_len   = '0;
    endfunction

    function automatic void leave_data();
        data_on    = 1'b0;
        data_tgt   = '0;
        data_cnt   = '0;
        hex_on     = 1'b0;
        nibble_low = 1'b0;
        hi_nibble  = '0;
    endfunction

    function automatic void predict_parser_result(input logic [1:0] fn,
                                                  input logic [7:0] ch,
                                                  input logic [8:0] len,
                                                  input logic hex);
        atcbp_pkg::result_t r;
        bit         hit;
        bit         byte_done;
        logic [4:0] d;
        logic [7:0] value;
        logic [7:0] n;
        bit         was_in_line;

        r         = '0;
        hit       = 1'b0;
        byte_done = 1'b0;
        value     = '0;
        case (fn)
            atcbp_pkg::FUNC_BYTE:
            begin
                if (data_on)
                begin
                    if (hex_on)
                    begin
                        d = hex_digit(ch);
                        if (d[4])
                        begin
                            r.kind        = atcbp_pkg::KIND_DATA_DONE;
                            r.count       = data_cnt;
                            r.done_status = atcbp_pkg::STATUS_ENC_ERR;
                            hit           = 1'b1;
                            leave_data();
                        end
                        else if (!nibble_low)
                        begin
                            hi_nibble  = d[3:0];
                            nibble_low = 1'b1;
                        end
                        else
                        begin
                            value      = {hi_nibble, d[3:0]};
                            nibble_low = 1'b0;
                            byte_done  = 1'b1;
                        end
                    end
                    else
                    begin
                        value     = ch;
                        byte_done = 1'b1;
                    end
                    if (byte_done)
                    begin
                        data_cnt    = data_cnt + 8'd1;
                        r.kind      = atcbp_pkg::KIND_DATA_BYTE;
                        r.out_byte  = value;
                        r.count     = data_cnt;
                        r.data_last = (data_cnt == data_tgt);
                        hit         = 1'b1;
                        if (r.data_last)
                            leave_data();
                    end
                end
                else if (ch == CH_LF)
                begin
                end
                else if (ch == CH_ESC)
                begin
                    if (line_phase == atcbp_pkg::PH_IN_LINE)
                    begin
                        r.kind  = atcbp_pkg::KIND_LINE_CANCEL;
                        r.count = line_len;
                        hit     = 1'b1;
                    end
                    clear_line();
                end
                else if (line_phase == atcbp_pkg::PH_GOT_A)
                begin
                    if (ch == CH_T || ch == CH_T_LC)
                    begin
                        line_len   = 8'd2;
                        line_phase = atcbp_pkg::PH_IN_LINE;
                    end
                    else
                        clear_line();
                end
                else if (line_phase == atcbp_pkg::PH_IN_LINE)
                begin
                    hit = 1'b1;
                    if (ch == CH_CR)
                    begin
                        r.kind  = atcbp_pkg::KIND_LINE_END;
                        r.count = line_len;
                        clear_line();
                    end
                    else if (line_len >= LINE_MAX)
                    begin
                        r.kind  = atcbp_pkg::KIND_LINE_OVFL;
                        r.count = line_len;
                        clear_line();
                    end
                    else
                    begin
                        line_len   = line_len + 8'd1;
                        r.kind     = atcbp_pkg::KIND_LINE_CHAR;
                        r.out_byte = (ch >= CH_A_LC && ch <= CH_Z_LC) ? ch - 8'h20 : ch;
                    end
                end
                else if (ch == CH_A || ch == CH_A_LC)
                begin
                    line_len   = 8'd1;
                    line_phase = atcbp_pkg::PH_GOT_A;
                end
                else
                    clear_line();
            end
            atcbp_pkg::FUNC_ARM:
            begin
                hit = 1'b1;
                if (data_on || len >= BUFFER_DEPTH)
                    r.kind = atcbp_pkg::KIND_ARM_REJECT;
                else if (len == 0)
                begin
                    r.kind      = atcbp_pkg::KIND_DATA_DONE;
                    r.data_last = 1'b1;
                end
                else
                begin
                    was_in_line = (line_phase == atcbp_pkg::PH_IN_LINE);
                    n           = line_len;
                    clear_line();
                    data_on    = 1'b1;
                    data_tgt   = len[7:0];
                    data_cnt   = '0;
                    hex_on     = hex;
                    nibble_low = 1'b0;
                    hi_nibble  = '0;
                    hit        = was_in_line;
                    r.kind     = atcbp_pkg::KIND_LINE_CANCEL;
                    r.count    = n;
                end
            end
            atcbp_pkg::FUNC_ABORT:
            begin
                if (data_on)
                begin
                    r.kind        = atcbp_pkg::KIND_DATA_DONE;
                    r.count       = data_cnt;
                    r.done_status = atcbp_pkg::STATUS_ABORTED;
                    hit           = 1'b1;
                    leave_data();
                end
            end
            default:
            begin
            end
        endcase
        if (hit)
            expected_results.push_back(r);
    endfunction

    function automatic void note_mismatch(input string what,
                                          input atcbp_pkg::result_t want,
                                          input atcbp_pkg::result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $write("[%0t] %s: want kind=%0d byte=%02h count=%0d last=%0d st=%0d",
                   $time, what, want.kind, want.out_byte, want.count, want.data_last,
                   want.done_status);
            $display(", got kind=%0d byte=%02h count=%0d last=%0d st=%0d",
                     got.kind, got.out_byte, got.count, got.data_last, got.done_status);
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------
    task automatic push_event(input logic [1:0] fn, input logic [7:0] ch,
                              input logic [8:0] len, input logic hex);
        parser_event_t ev;
        ev.func       = fn;
        ev.rx_byte    = ch;
        ev.arm_length = len;
        ev.arm_hex    = hex;
        event_q.push_back(ev);
    endtask

    task automatic push_byte(input logic [7:0] ch);
        push_event(atcbp_pkg::FUNC_BYTE, ch, 9'($urandom_range(511)),
                   1'($urandom_range(1)));
    endtask

    task automatic push_arm(input logic [8:0] len, input logic hex);
        push_event(atcbp_pkg::FUNC_ARM, 8'($urandom_range(255)), len, hex);
    endtask

    task automatic push_abort();
        push_event(atcbp_pkg::FUNC_ABORT, 8'($urandom_range(255)),
                   9'($urandom_range(511)), 1'($urandom_range(1)));
    endtask

    function automatic logic [7:0] line_char();
        logic [7:0] ch;
        case ($urandom_range(3))
            0:       ch = 8'($urandom_range(CH_A_LC, CH_Z_LC));
            1:       ch = 8'($urandom_range(CH_A, 8'h5A));
            default: ch = 8'($urandom_range(255));
        endcase
        if (ch == CH_CR || ch == CH_ESC)
            ch = CH_A_LC;
        return ch;
    endfunction

    function automatic logic [7:0] hex_char();
        int i;
        i = $urandom_range(21);
        if (i < 10)
            return CH_ZERO + 8'(i);
        if (i < 16)
            return CH_A_LC + 8'(i - 10);
        return CH_A + 8'(i - 16);
    endfunction

    function automatic logic [7:0] bad_hex_char();
        logic [7:0] ch;
        logic [4:0] d;
        ch = 8'($urandom_range(255));
        d  = hex_digit(ch);
        while (!d[4])
        begin
            ch = 8'($urandom_range(255));
            d  = hex_digit(ch);
        end
        return ch;
    endfunction

    task automatic gen_line(input int n);
        int pick;
        if ($urandom_range(99) < 20)
            push_byte(line_char());
        push_byte($urandom_range(1) ? CH_A : CH_A_LC);
        if ($urandom_range(99) < 5)
            push_byte(line_char());
        else
            push_byte($urandom_range(1) ? CH_T : CH_T_LC);
        for (int i = 0; i < n; i++)
            push_byte(line_char());
        pick = $urandom_range(99);
        if (pick < 75)
            push_byte(CH_CR);
        else if (pick < 88)
            push_byte(CH_ESC);
        else if (pick < 94)
            push_arm(9'($urandom_range(8)), 1'($urandom_range(1)));
    endtask

    task automatic gen_data_read();
        int   pick;
        int   len;
        logic hex;
        pick = $urandom_range(99);
        if (pick < 3)
            len = $urandom_range(BUFFER_DEPTH, 511);
        else if (pick < 6)
            len = $urandom_range(200, BUFFER_DEPTH - 1);
        else if (pick < 10)
            len = 0;
        else
            len = $urandom_range(1, 8);
        hex = 1'($urandom_range(1));
        push_arm(9'(len), hex);
        if (len == 0 || len >= BUFFER_DEPTH)
            return;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                push_abort();
                return;
            end
            if (pick < 7)
                push_arm(9'($urandom_range(511)), 1'($urandom_range(1)));
            if (hex)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    if ($urandom_range(99) < 3)
                    begin
                        push_byte(bad_hex_char());
                        return;
                    end
                    push_byte(hex_char());
                end
            end
            else
                push_byte(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: present the next beat at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_blk
        parser_event_t ev;
        if (rst_n)
        begin
            calm = (cycle_cnt % 4000) < 900;
            if (!in_ch.valid || in_fire)
            begin
                if (event_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    ev = event_q.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.func       <= ev.func;
                    in_ch.rx_byte    <= ev.rx_byte;
                    in_ch.arm_length <= ev.arm_length;
                    in_ch.arm_hex    <= ev.arm_hex;
                end
                else
                    in_ch.valid <= 1'b0;
            end
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predict on input beats, check output beats
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : sample_blk
        atcbp_pkg::result_t want;
        atcbp_pkg::result_t got;
        if (!rst_n)
            in_fire = 1'b0;
        else
        begin
            cycle_cnt++;
            in_fire = in_ch.valid && in_ch.ready;
            if (in_fire)
            begin
                beats_in++;
                predict_parser_result(in_ch.func, in_ch.rx_byte, in_ch.arm_length,
                                      in_ch.arm_hex);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.kind        = out_ch.kind;
                got.out_byte    = out_ch.out_byte;
                got.count       = out_ch.count;
                got.data_last   = out_ch.data_last;
                got.done_status = out_ch.done_status;
                beats_out++;
                if (got.kind < 7)
                    kind_seen[got.kind]++;
                if (expected_results.size() == 0)
                    note_mismatch("unexpected result", '0, got);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.out_byte !== want.out_byte
                        || got.count !== want.count || got.data_last !== want.data_last
                        || got.done_status !== want.done_status)
                        note_mismatch("result mismatch", want, got);
                end
            end
            if (cycle_cnt >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                         expected_results.size());
                $display("tb_at_command_byte_parser_top NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_blk
        int directed;
        int seq_no;
        int pick;

        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.func       = atcbp_pkg::FUNC_BYTE;
        in_ch.rx_byte    = '0;
        in_ch.arm_length = '0;
        in_ch.arm_hex    = 1'b0;
        out_ch.ready     = 1'b0;
        cycle_cnt        = 0;
        beats_in         = 0;
        beats_out        = 0;
        mismatches       = 0;
        in_fire          = 1'b0;
        calm             = 1'b0;
        foreach (kind_seen[i])
            kind_seen[i] = 0;
        clear_line();
        leave_data();

        // line with lower case, LF ignored, CR end
        push_byte(CH_A);
        push_byte(CH_T);
        push_byte(CH_H_LC);
        push_byte(CH_Z_LC);
        push_byte(CH_LF);
        push_byte(CH_CR);
        // lower case prefix then cancel
        push_byte(CH_A_LC);
        push_byte(CH_T_LC);
        push_byte(CH_ESC);
        // broken prefix, CR and ESC while waiting
        push_byte(CH_A);
        push_byte(CH_X_LC);
        push_byte(CH_CR);
        push_byte(CH_ESC);
        // abort outside data mode, unused code, zero and oversize arms
        push_abort();
        push_event(2'd3, 8'hFF, 9'h1FF, 1'b1);
        push_arm(9'd0, 1'b0);
        push_arm(9'd256, 1'b1);
        push_arm(9'h1FF, 1'b0);
        // arm in line drops it, arm in data mode rejected, hex pair then bad digit
        push_byte(CH_A);
        push_byte(CH_T);
        push_arm(9'd2, 1'b1);
        push_arm(9'd5, 1'b0);
        push_byte(CH_FOUR);
        push_byte(CH_F_LC);
        push_byte(CH_G_UC);
        // binary last byte, then abort mid read
        push_arm(9'd1, 1'b0);
        push_byte(8'hFF);
        push_arm(9'd3, 1'b1);
        push_byte(CH_F_UC);
        push_byte(CH_ZERO);
        push_abort();
        directed = event_q.size();

        seq_no = 0;
        while (event_q.size() < directed + RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (seq_no == 3 || pick < 2)
                gen_line(252 + $urandom_range(4));
            else if (pick < 50)
                gen_line($urandom_range(20));
            else if (pick < 85)
                gen_data_read();
            else
                repeat ($urandom_range(1, 4))
                    push_event(2'($urandom_range(3)), 8'($urandom_range(255)),
                               9'($urandom_range(511)), 1'($urandom_range(1)));
            seq_no++;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (event_q.size() == 0 && !in_ch.valid);
        wait (expected_results.size() == 0);
        repeat (10) @(posedge clk);

        $display("%0d beats in, %0d results; chars %0d, ends %0d, cancels %0d, overflows %0d",
                 beats_in, beats_out, kind_seen[atcbp_pkg::KIND_LINE_CHAR],
                 kind_seen[atcbp_pkg::KIND_LINE_END],
                 kind_seen[atcbp_pkg::KIND_LINE_CANCEL],
                 kind_seen[atcbp_pkg::KIND_LINE_OVFL]);
        $display("data bytes %0d, data reads finished %0d, arms rejected %0d, mismatches %0d",
                 kind_seen[atcbp_pkg::KIND_DATA_BYTE], kind_seen[atcbp_pkg::KIND_DATA_DONE],
                 kind_seen[atcbp_pkg::KIND_ARM_REJECT], mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_at_command_byte_parser_top OK");
        else
            $display("tb_at_command_byte_parser_top NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
design/atcbp_pkg.sv
design/atcbp_in_if.sv
design/atcbp_out_if.sv
design/atcbp_core.sv
design/atcbp_out_queue.sv
design/at_command_byte_parser_top.sv
tb/tb_at_command_byte_parser_top.sv
